@@ src/char_lcd_nibble_writer_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef CHAR_LCD_NIBBLE_WRITER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLNW_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("char_lcd_nibble_writer: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CLNW_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("char_lcd_nibble_writer: next-cycle check failed");

`endif

@@ src/clnw_pkg.sv @@
package clnw_pkg;

	// Request codes on req_type.
	typedef enum logic [2:0] {
		REQ_CMD    = 3'd0,
		REQ_CHAR   = 3'd1,
		REQ_CURSOR = 3'd2,
		REQ_CLEAR  = 3'd3,
		REQ_INIT   = 3'd4
	} req_e_t;

	// Bus phases of one byte.
	typedef enum logic [1:0] {
		PH_E_HOLD = 2'd0,
		PH_HI     = 2'd1,
		PH_E_HI   = 2'd2,
		PH_LO     = 2'd3
	} phase_t;

	// Display command bytes.
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CURSOR_LINE0 = 8'h80;
	localparam logic [7:0] CURSOR_LINE1 = 8'hC0;
	localparam logic [7:0] INIT_HOME    = 8'h02;
	localparam logic [7:0] INIT_FUNC    = 8'h28;
	localparam logic [7:0] INIT_DISPLAY = 8'h0C;

	// Initialization sends four bytes.
	localparam int INIT_LEN = 4;
	localparam int INIT_IW  = $clog2(INIT_LEN);
	localparam logic [INIT_IW-1:0] INIT_LAST = INIT_IW'(INIT_LEN - 1);

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// One byte-level job handed from front to back.
	typedef struct packed {
		logic       rs;
		logic       init;
		logic [7:0] byte_val;
	} job_t;

	// Byte of the initialization sequence at a given position.
	function automatic logic [7:0] init_byte(input logic [INIT_IW-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0:    b = INIT_HOME;
			2'd1:    b = INIT_FUNC;
			2'd2:    b = INIT_DISPLAY;
			default: b = CMD_CLEAR;
		endcase
		return b;
	endfunction

endpackage

@@ src/clnw_front.sv @@
module clnw_front (
	input  logic                 push,
	input  logic [2:0]           req_type,
	input  logic [7:0]           data_byte,
	input  logic                 row_select,
	input  logic [5:0]           column,
	input  logic                 q_full,
	output logic                 q_wr,
	output clnw_pkg::job_t       q_job
);

	logic kind_ok;

	// Classify the request into a job for the back end.
	always_comb begin
		kind_ok        = 1'b1;
		q_job.rs       = 1'b0;
		q_job.init     = 1'b0;
		q_job.byte_val = data_byte;
		unique case (req_type)
			clnw_pkg::REQ_CMD: begin
				q_job.byte_val = data_byte;
			end
			clnw_pkg::REQ_CHAR: begin
				q_job.rs       = 1'b1;
				q_job.byte_val = data_byte;
			end
			clnw_pkg::REQ_CURSOR: begin
				// The column never carries past the line base, so the sum fits.
				q_job.byte_val = (row_select ? clnw_pkg::CURSOR_LINE1 : clnw_pkg::CURSOR_LINE0)
				                 + {2'b00, column};
			end
			clnw_pkg::REQ_CLEAR: begin
				q_job.byte_val = clnw_pkg::CMD_CLEAR;
			end
			clnw_pkg::REQ_INIT: begin
				q_job.init     = 1'b1;
				q_job.byte_val = clnw_pkg::CMD_CLEAR;
			end
			default: begin
				kind_ok = 1'b0;
			end
		endcase
	end

	// Unused request codes are taken and dropped.
	assign q_wr = push && !q_full && kind_ok;

endmodule

@@ src/clnw_queue.sv @@
module clnw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  clnw_pkg::job_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output clnw_pkg::job_t rd_data,
	output logic           empty
);

	clnw_pkg::job_t                  mem [clnw_pkg::QUEUE_DEPTH];
	logic [clnw_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [clnw_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [clnw_pkg::QUEUE_AW:0]     count_q;

	assign full    = (count_q == (clnw_pkg::QUEUE_AW+1)'(clnw_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/clnw_back.sv @@
module clnw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  clnw_pkg::job_t q_job,
	output logic           q_rd,
	input  logic           pop,
	output logic           empty,
	output logic           reg_select,
	output logic           read_write,
	output logic           enable,
	output logic [3:0]     data_nibble,
	output logic           last
);

	clnw_pkg::phase_t               phase_q;
	clnw_pkg::phase_t               phase_next;
	logic [clnw_pkg::INIT_IW-1:0]   idx_q;
	logic [3:0]                     held_q;
	logic                           out_valid_q;
	logic                           rs_q;
	logic                           en_q;
	logic [3:0]                     nib_q;
	logic                           last_q;

	logic                           advance;
	logic [7:0]                     cur_byte;
	logic                           last_byte;
	logic                           ph_en;
	logic [3:0]                     ph_nib;
	logic                           ph_last;

	// A phase is produced whenever a job waits and the output slot frees up.
	assign advance   = !q_empty && (!out_valid_q || pop);
	assign cur_byte  = q_job.init ? clnw_pkg::init_byte(idx_q) : q_job.byte_val;
	assign last_byte = !q_job.init || (idx_q == clnw_pkg::INIT_LAST);
	assign q_rd      = advance && (phase_q == clnw_pkg::PH_LO) && last_byte;

	// Phase sequencer: next phase and the bus values of the current one.
	always_comb begin
		phase_next = phase_q;
		ph_en      = 1'b0;
		ph_nib     = held_q;
		ph_last    = 1'b0;
		unique case (phase_q)
			clnw_pkg::PH_E_HOLD: begin
				ph_en  = 1'b1;
				ph_nib = held_q;
				if (advance) phase_next = clnw_pkg::PH_HI;
			end
			clnw_pkg::PH_HI: begin
				ph_nib = cur_byte[7:4];
				if (advance) phase_next = clnw_pkg::PH_E_HI;
			end
			clnw_pkg::PH_E_HI: begin
				ph_en  = 1'b1;
				ph_nib = cur_byte[7:4];
				if (advance) phase_next = clnw_pkg::PH_LO;
			end
			clnw_pkg::PH_LO: begin
				ph_nib  = cur_byte[3:0];
				ph_last = last_byte;
				if (advance) phase_next = clnw_pkg::PH_E_HOLD;
			end
			default: begin
				phase_next = clnw_pkg::PH_E_HOLD;
			end
		endcase
	end

	// Sequencer state, init index and the nibble left on the bus.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= clnw_pkg::PH_E_HOLD;
			idx_q   <= '0;
			held_q  <= '0;
		end else begin
			phase_q <= phase_next;
			if (advance && (phase_q == clnw_pkg::PH_LO)) begin
				held_q <= cur_byte[3:0];
				idx_q  <= last_byte ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Output slot valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			rs_q   <= q_job.rs;
			en_q   <= ph_en;
			nib_q  <= ph_nib;
			last_q <= ph_last;
		end
	end

	assign empty       = !out_valid_q;
	assign reg_select  = rs_q;
	assign read_write  = 1'b0;
	assign enable      = en_q;
	assign data_nibble = nib_q;
	assign last        = last_q;

endmodule

@@ src/char_lcd_nibble_writer.sv @@
// Channel   Handshake            Payload
// request   push / full          req_type, data_byte, row_select, column
// phase     empty / pop          reg_select, read_write, enable, data_nibble, last
//
// Each byte gives four bus phases, one per cycle while popped, from the back end sequencer;
// initialize gives sixteen, every other request four, unused codes none.
// Requests pass through a four-entry queue, so up to four wait while phases drain.
// The output register frees each cycle it is popped, so phases stream with no gaps.
// Reset clears the queue, the sequencer and the held nibble (zero); no clearing pass.
module char_lcd_nibble_writer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] req_type,
	input  logic [7:0] data_byte,
	input  logic       row_select,
	input  logic [5:0] column,
	output logic       empty,
	input  logic       pop,
	output logic       reg_select,
	output logic       read_write,
	output logic       enable,
	output logic [3:0] data_nibble,
	output logic       last
);

	logic           q_wr;
	logic           q_rd;
	logic           q_empty;
	clnw_pkg::job_t wr_job;
	clnw_pkg::job_t rd_job;

	// Front end: classify requests into byte jobs.
	clnw_front u_front (
		.push       (push),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.row_select (row_select),
		.column     (column),
		.q_full     (full),
		.q_wr       (q_wr),
		.q_job      (wr_job)
	);

	// Job queue between front and back.
	clnw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (wr_job),
		.full    (full),
		.rd_en   (q_rd),
		.rd_data (rd_job),
		.empty   (q_empty)
	);

	// Back end: emit bus phases.
	clnw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_job       (rd_job),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.reg_select  (reg_select),
		.read_write  (read_write),
		.enable      (enable),
		.data_nibble (data_nibble),
		.last        (last)
	);

endmodule

@@ src/clnw_checker.sv @@
`include "char_lcd_nibble_writer_macros.svh"

module clnw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       read_write,
	input logic       enable,
	input logic [3:0] data_nibble,
	input logic       last
);

	logic       expect_en_q;
	logic [3:0] prev_nib_q;

	// Track the E level expected next and the nibble of the last popped phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_en_q <= 1'b1;
			prev_nib_q  <= '0;
		end else if (pop && !empty) begin
			expect_en_q <= !expect_en_q;
			prev_nib_q  <= data_nibble;
		end
	end

	`CLNW_ASSERT_NOW(a_rw_write, clk, arst_n, !empty, read_write == 1'b0)
	`CLNW_ASSERT_NOW(a_en_alternates, clk, arst_n, !empty, enable == expect_en_q)
	`CLNW_ASSERT_NOW(a_en_high_holds_bus, clk, arst_n, !empty && enable, data_nibble == prev_nib_q)
	`CLNW_ASSERT_NOW(a_last_with_e_low, clk, arst_n, !empty && last, enable == 1'b0)
	`CLNW_ASSERT_NEXT(a_stall_holds, clk, arst_n, !empty && !pop, !empty && $stable(data_nibble))

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_HALF = 2;
	localparam int RESET_CYCLES = 5;
	localparam int LIMIT_CYCLES = 200000;
	localparam int IDLE_PERCENT = 16;
	localparam int STALL_CYCLES = 300;
	localparam int SETTLE_CYCLES = 24;

	// Request codes with no meaning; the block drops them.
	localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
	localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
	localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

	// One bus phase as it appears on the result ports.
	typedef struct {
		logic       rs;
		logic       rw;
		logic       en;
		logic [3:0] nib;
		logic       fin;
	} lcd_phase_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [2:0] req_type;
	logic [7:0] data_byte;
	logic       row_select;
	logic [5:0] column;
	logic       empty;
	logic       pop;
	logic       reg_select;
	logic       read_write;
	logic       enable;
	logic [3:0] data_nibble;
	logic       last;

	lcd_phase_t bus_phases_due[$];
	logic [3:0] pins_nibble;
	logic [7:0] init_bytes[clnw_pkg::INIT_LEN] = '{clnw_pkg::INIT_HOME, clnw_pkg::INIT_FUNC,
		clnw_pkg::INIT_DISPLAY, clnw_pkg::CMD_CLEAR};

	int  mismatches = 0;
	int  phases_checked = 0;
	int  requests_sent = 0;
	int  requests_ignored = 0;
	int  full_cycles = 0;
	int  cycle_count = 0;
	bit  send_gaps = 1'b0;
	bit  recv_gaps = 1'b0;
	bit  stall_req = 1'b0;
	int  stall_left = 0;

	char_lcd_nibble_writer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.row_select (row_select),
		.column     (column),
		.empty      (empty),
		.pop        (pop),
		.reg_select (reg_select),
		.read_write (read_write),
		.enable     (enable),
		.data_nibble(data_nibble),
		.last       (last)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: a run that exceeds the cycle budget has hung; also counts cycles in which push meets full.
	always @(posedge clk) begin
		cycle_count++;
		if (push && full)
			full_cycles++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d phases still due.",
				cycle_count, bus_phases_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Appends the four phases of one byte and updates the nibble left on the pins.
	function automatic void emit_byte(input logic rs, input logic [7:0] b, input logic fin);
		lcd_phase_t ph;
		ph.rs = rs;
		ph.rw = 1'b0;
		ph.fin = 1'b0;
		ph.en = 1'b1;
		ph.nib = pins_nibble;
		bus_phases_due.push_back(ph);
		ph.en = 1'b0;
		ph.nib = b[7:4];
		bus_phases_due.push_back(ph);
		ph.en = 1'b1;
		bus_phases_due.push_back(ph);
		ph.en = 1'b0;
		ph.nib = b[3:0];
		ph.fin = fin;
		bus_phases_due.push_back(ph);
		pins_nibble = b[3:0];
	endfunction

	// Works out the bus phases that one accepted request produces.
	function automatic void predict_bus_phases(input logic [2:0] kind, input logic [7:0] b,
			input logic row, input logic [5:0] col);
		case (kind)
			clnw_pkg::REQ_CMD:    emit_byte(1'b0, b, 1'b1);
			clnw_pkg::REQ_CHAR:   emit_byte(1'b1, b, 1'b1);
			clnw_pkg::REQ_CURSOR: emit_byte(1'b0,
				(row ? clnw_pkg::CURSOR_LINE1 : clnw_pkg::CURSOR_LINE0) + 8'(col), 1'b1);
			clnw_pkg::REQ_CLEAR:  emit_byte(1'b0, clnw_pkg::CMD_CLEAR, 1'b1);
			clnw_pkg::REQ_INIT: begin
				for (int i = 0; i < clnw_pkg::INIT_LEN; i++)
					emit_byte(1'b0, init_bytes[i], i == clnw_pkg::INIT_LEN - 1);
			end
			default: requests_ignored++;
		endcase
	endfunction

	// Offers one request and waits for the transaction; push stays high afterwards.
	task automatic send_request(input logic [2:0] kind, input logic [7:0] b,
			input logic row, input logic [5:0] col);
		while (send_gaps && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		req_type <= kind;
		data_byte <= b;
		row_select <= row;
		column <= col;
		do @(posedge clk); while (full);
		predict_bus_phases(kind, b, row, col);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic stop_sending;
		push <= 1'b0;
		@(negedge clk);
	endtask

	// Random request: mostly valid kinds, now and then an unused code.
	task automatic send_random_request;
		logic [2:0] kind;
		if ($urandom_range(99) < 8)
			kind = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
		else
			kind = 3'($urandom_range(clnw_pkg::REQ_INIT, clnw_pkg::REQ_CMD));
		send_request(kind, 8'($urandom), 1'($urandom), 6'($urandom));
	endtask

	task automatic wait_drained;
		while (bus_phases_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: pops with random gaps when they are enabled, or holds off completely while a stall is running.
	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && stall_req) begin
				stall_req = 1'b0;
				stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (recv_gaps && $urandom_range(99) < IDLE_PERCENT) begin
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Checker: each popped phase is compared with the oldest one due.
	always @(posedge clk) begin
		lcd_phase_t want;
		if (arst_n && pop && !empty) begin
			if (bus_phases_due.size() == 0) begin
				report_mismatch($sformatf("unexpected phase en=%0b nib=%h last=%0b",
					enable, data_nibble, last));
			end else begin
				want = bus_phases_due.pop_front();
				phases_checked++;
				if (reg_select !== want.rs)
					report_mismatch($sformatf("reg_select %b, want %b", reg_select, want.rs));
				if (read_write !== want.rw)
					report_mismatch($sformatf("read_write %b, want %b", read_write, want.rw));
				if (enable !== want.en)
					report_mismatch($sformatf("enable %b, want %b", enable, want.en));
				if (data_nibble !== want.nib)
					report_mismatch($sformatf("data_nibble %h, want %h", data_nibble, want.nib));
				if (last !== want.fin)
					report_mismatch($sformatf("last %b, want %b", last, want.fin));
			end
		end
	end

	// Extremes of every field, every request kind and the unused codes.
	task automatic test_directed;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		send_request(clnw_pkg::REQ_CMD, 8'h00, 1'b0, 6'd0);
		send_request(clnw_pkg::REQ_CMD, 8'hFF, 1'b1, 6'd63);
		send_request(clnw_pkg::REQ_CHAR, 8'h00, 1'b1, 6'd63);
		send_request(clnw_pkg::REQ_CHAR, 8'hFF, 1'b0, 6'd0);
		send_request(clnw_pkg::REQ_CHAR, 8'hA5, 1'b0, 6'd21);
		send_request(clnw_pkg::REQ_CHAR, 8'h5A, 1'b1, 6'd42);
		send_request(clnw_pkg::REQ_CURSOR, 8'hFF, 1'b0, 6'd0);
		send_request(clnw_pkg::REQ_CURSOR, 8'h00, 1'b0, 6'd63);
		send_request(clnw_pkg::REQ_CURSOR, 8'hFF, 1'b1, 6'd0);
		send_request(clnw_pkg::REQ_CURSOR, 8'h00, 1'b1, 6'd63);
		send_request(clnw_pkg::REQ_CLEAR, 8'hFF, 1'b1, 6'd63);
		send_request(clnw_pkg::REQ_INIT, 8'hFF, 1'b1, 6'd63);
		send_request(REQ_UNUSED_LO, 8'hFF, 1'b1, 6'd63);
		send_request(clnw_pkg::REQ_CHAR, 8'h3C, 1'b0, 6'd0);
		send_request(REQ_UNUSED_MID, 8'h00, 1'b0, 6'd0);
		send_request(REQ_UNUSED_HI, 8'h81, 1'b1, 6'd33);
		send_request(clnw_pkg::REQ_INIT, 8'h00, 1'b0, 6'd0);
		send_request(clnw_pkg::REQ_CLEAR, 8'h00, 1'b0, 6'd0);
		send_request(clnw_pkg::REQ_CMD, 8'h96, 1'b0, 6'd5);
		stop_sending();
		wait_drained();
	endtask

	// Long stretch with both sides running flat out.
	task automatic test_streaming;
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		repeat (60) send_random_request();
		stop_sending();
		wait_drained();
	endtask

	// The receiver holds off while requests keep coming, so the queue fills.
	task automatic test_backpressure;
		send_gaps = 1'b0;
		recv_gaps = 1'b1;
		stall_req = 1'b1;
		repeat (24) send_random_request();
		stop_sending();
		wait_drained();
	endtask

	// Random requests with random gaps on both sides.
	task automatic test_random;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		repeat (200) send_random_request();
		stop_sending();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		req_type = clnw_pkg::REQ_CMD;
		data_byte = 8'h00;
		row_select = 1'b0;
		column = 6'd0;
		pins_nibble = 4'h0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_streaming();
		test_backpressure();
		test_random();

		if (bus_phases_due.size() != 0)
			report_mismatch($sformatf("%0d phases never arrived", bus_phases_due.size()));
		$display("Sent %0d requests (%0d with unused codes), checked %0d bus phases.",
			requests_sent, requests_ignored, phases_checked);
		$display("Input held off for %0d cycles, %0d mismatches.", full_cycles, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ char_lcd_nibble_writer.f @@
+incdir+src
src/clnw_pkg.sv
src/clnw_front.sv
src/clnw_queue.sv
src/clnw_back.sv
src/char_lcd_nibble_writer.sv
src/clnw_checker.sv
test/testbench.sv
